>>> hdl/pla_pkg.sv
// ---------------------------------------------------------------------------
// pla_pkg: shared definitions for the polyline length accumulator
// Widths, the control state encoding, unit result bundles and the
// absolute coordinate difference.
// ---------------------------------------------------------------------------
package pla_pkg;

	// coordinate and total widths, Q7.8 coordinates, 8 fraction bits in the total
	localparam int COORD_W = 16;
	localparam int TOTAL_W = 32;

	// magnitude of a coordinate difference always fits in COORD_W bits
	localparam int DIFF_W = COORD_W;
	// one square, and the sum of three squares with two guard bits
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = SQ_W + 2;

	// squaring consumes two multiplier bits per cycle
	localparam int DIGIT_W    = 2;
	localparam int MUL_STEPS  = DIFF_W / DIGIT_W;
	localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

	// restoring square root, one root bit per cycle
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int ROOT_CNT_W = $clog2(ROOT_W);

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROOT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] sum;
	} sq_res_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} rt_res_t;

	// |a - b| for two signed coordinates
	function automatic logic [DIFF_W-1:0] abs_diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] d;
		logic        [COORD_W:0] mag;
		d   = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
		mag = d[COORD_W] ? (~d + 1'b1) : d;
		return mag[DIFF_W-1:0];
	endfunction

endpackage

>>> hdl/pla_sumsq.sv
// ---------------------------------------------------------------------------
// pla_sumsq: digit-serial sum of three squares
// Squares three magnitudes in parallel, two multiplier bits per cycle, and
// adds all partial products into one accumulator.
// ---------------------------------------------------------------------------
module pla_sumsq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pla_pkg::DIFF_W-1:0]     dx,
	input  logic [pla_pkg::DIFF_W-1:0]     dy,
	input  logic [pla_pkg::DIFF_W-1:0]     dz,
	output pla_pkg::sq_res_t               res
);

	logic                           busy_q;
	logic                           done_q;
	logic [pla_pkg::MUL_CNT_W-1:0]  cnt_q;
	logic [pla_pkg::DIFF_W-1:0]     mpx_q, mpy_q, mpz_q;
	logic [pla_pkg::SQ_W-1:0]       mcx_q, mcy_q, mcz_q;
	logic [pla_pkg::SUM_W-1:0]      acc_q;
	logic [pla_pkg::SUM_W-1:0]      pp_sum;

	// partial product of the multiplicand and one two-bit digit
	function automatic logic [pla_pkg::SUM_W-1:0] pprod(
		input logic [pla_pkg::SQ_W-1:0]    mc,
		input logic [pla_pkg::DIGIT_W-1:0] dig
	);
		logic [pla_pkg::SUM_W-1:0] m1;
		m1 = {{(pla_pkg::SUM_W-pla_pkg::SQ_W){1'b0}}, mc};
		case (dig)
			2'd0:    return '0;
			2'd1:    return m1;
			2'd2:    return m1 << 1;
			default: return m1 + (m1 << 1);
		endcase
	endfunction

	assign pp_sum = pprod(mcx_q, mpx_q[pla_pkg::DIGIT_W-1:0])
	              + pprod(mcy_q, mpy_q[pla_pkg::DIGIT_W-1:0])
	              + pprod(mcz_q, mpz_q[pla_pkg::DIGIT_W-1:0]);

	// control: run MUL_STEPS digits, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pla_pkg::MUL_CNT_W'(pla_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift multipliers right, multiplicands left, accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			mpx_q <= dx;
			mpy_q <= dy;
			mpz_q <= dz;
			mcx_q <= {{(pla_pkg::SQ_W-pla_pkg::DIFF_W){1'b0}}, dx};
			mcy_q <= {{(pla_pkg::SQ_W-pla_pkg::DIFF_W){1'b0}}, dy};
			mcz_q <= {{(pla_pkg::SQ_W-pla_pkg::DIFF_W){1'b0}}, dz};
			acc_q <= '0;
		end else if (busy_q) begin
			mpx_q <= mpx_q >> pla_pkg::DIGIT_W;
			mpy_q <= mpy_q >> pla_pkg::DIGIT_W;
			mpz_q <= mpz_q >> pla_pkg::DIGIT_W;
			mcx_q <= mcx_q << pla_pkg::DIGIT_W;
			mcy_q <= mcy_q << pla_pkg::DIGIT_W;
			mcz_q <= mcz_q << pla_pkg::DIGIT_W;
			acc_q <= acc_q + pp_sum;
		end
	end

	assign res.done = done_q;
	assign res.sum  = acc_q;

endmodule

>>> hdl/pla_isqrt.sv
// ---------------------------------------------------------------------------
// pla_isqrt: bit-serial integer square root
// Restoring method: two radicand bits in and one root bit out per cycle,
// result is floor(sqrt(radicand)).
// ---------------------------------------------------------------------------
module pla_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pla_pkg::SUM_W-1:0]   rad,
	output pla_pkg::rt_res_t            res
);

	logic                            busy_q;
	logic                            done_q;
	logic [pla_pkg::ROOT_CNT_W-1:0]  cnt_q;
	logic [pla_pkg::SUM_W-1:0]       rad_q;
	logic [pla_pkg::REM_W-1:0]       rem_q;
	logic [pla_pkg::ROOT_W-1:0]      root_q;
	logic [pla_pkg::REM_W-1:0]       rem_sh;
	logic [pla_pkg::REM_W-1:0]       trial;
	logic                            fits;

	// bring in the next two radicand bits and try root*4+1
	assign rem_sh = {rem_q[pla_pkg::REM_W-3:0], rad_q[pla_pkg::SUM_W-1 -: 2]};
	assign trial  = {{(pla_pkg::REM_W-pla_pkg::ROOT_W-2){1'b0}}, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	// control: ROOT_W iterations, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pla_pkg::ROOT_CNT_W'(pla_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift radicand, update remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[pla_pkg::ROOT_W-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.root = root_q;

endmodule

>>> hdl/polyline_length_accumulator_top.sv
// ---------------------------------------------------------------------------
// polyline_length_accumulator_top: running Euclidean length of a path
// Accumulates floor(sqrt(dx^2+dy^2[+dz^2])) per segment, saturating, and
// emits the total on the last point of a path.
// ---------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                  tuser / tlast
//  s_*      in   x_coord[15:0] y_coord z_coord       tuser: first_point, tlast: last_point
//  m_*      out  path_length[31:0]                   tuser: saturated
//  cfg_*    in   cfg_wr_data: three_dimensional      write on cfg_wr_en
//
//  A point that adds a segment holds off the next point from acceptance
//  through the load, the two-bit squaring digits, the bit-serial square root
//  and the accumulate. A first point passes only through ST_FIN in between.
//  Reset clears the previous point, total, flag and mode to zero.
//  A finished total waits in the output register; a later last point holds in
//  its final cycle until that register is taken.
// ---------------------------------------------------------------------------
module polyline_length_accumulator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,  // three_dimensional
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,      // x_coord, y_coord, z_coord
	input  logic [0:0]  s_tuser,      // first_point
	input  logic        s_tlast,      // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,      // path_length
	output logic [0:0]  m_tuser       // saturated
);

	localparam int CW = pla_pkg::COORD_W;

	pla_pkg::state_t              state_q, state_d;
	logic                         mode_3d_q;
	logic [CW-1:0]                prev_x_q, prev_y_q, prev_z_q;
	logic [pla_pkg::TOTAL_W-1:0]  total_q;
	logic                         clamp_q;
	logic                         last_q;
	logic                         out_valid_q;
	logic [pla_pkg::TOTAL_W-1:0]  out_len_q;
	logic                         out_sat_q;

	logic [CW-1:0]                in_x, in_y, in_z;
	logic                         in_first;
	logic                         accept;
	logic                         sq_start;
	logic [pla_pkg::DIFF_W-1:0]   dx, dy, dz;
	pla_pkg::sq_res_t             sq_res;
	pla_pkg::rt_res_t             rt_res;
	logic [pla_pkg::TOTAL_W:0]    total_sum;
	logic                         out_load;

	assign in_x     = s_tdata[CW-1:0];
	assign in_y     = s_tdata[2*CW-1:CW];
	assign in_z     = s_tdata[3*CW-1:2*CW];
	assign in_first = s_tuser[0];
	assign accept   = s_tvalid && s_tready;
	assign sq_start = accept && !in_first;

	// segment differences against the stored point; drop z in 2D mode
	assign dx = pla_pkg::abs_diff(in_x, prev_x_q);
	assign dy = pla_pkg::abs_diff(in_y, prev_y_q);
	assign dz = mode_3d_q ? pla_pkg::abs_diff(in_z, prev_z_q) : '0;

	pla_sumsq u_sumsq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.dx     (dx),
		.dy     (dy),
		.dz     (dz),
		.res    (sq_res)
	);

	pla_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_res.done),
		.rad    (sq_res.sum),
		.res    (rt_res)
	);

	// saturating add of the new segment
	assign total_sum = {1'b0, total_q}
	                 + {{(pla_pkg::TOTAL_W + 1 - pla_pkg::ROOT_W){1'b0}}, rt_res.root};

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			pla_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = in_first ? pla_pkg::ST_FIN : pla_pkg::ST_MUL;
				end
			end
			pla_pkg::ST_MUL: begin
				if (sq_res.done) begin
					state_d = pla_pkg::ST_ROOT;
				end
			end
			pla_pkg::ST_ROOT: begin
				if (rt_res.done) begin
					state_d = pla_pkg::ST_FIN;
				end
			end
			pla_pkg::ST_FIN: begin
				if (!last_q) begin
					state_d = pla_pkg::ST_IDLE;
				end else if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = pla_pkg::ST_IDLE;
				end
			end
			default: state_d = pla_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_3d_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_3d_q <= cfg_wr_data;
		end
	end

	// path state: previous point, total, sticky clamp flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			total_q  <= '0;
			clamp_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (accept) begin
				prev_x_q <= in_x;
				prev_y_q <= in_y;
				prev_z_q <= in_z;
				last_q   <= s_tlast;
				if (in_first) begin
					total_q <= '0;
					clamp_q <= 1'b0;
				end
			end
			if (rt_res.done) begin
				if (total_sum[pla_pkg::TOTAL_W]) begin
					total_q <= pla_pkg::TOTAL_MAX;
					clamp_q <= 1'b1;
				end else begin
					total_q <= total_sum[pla_pkg::TOTAL_W-1:0];
				end
			end
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_len_q <= total_q;
			out_sat_q <= clamp_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_len_q;
	assign m_tuser[0] = out_sat_q;

	// a segment always starts the squaring unit
	a_seg_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser[0]) |=> (state_q == pla_pkg::ST_MUL))
		else $error("segment item did not start squaring");

	// unit completions line up with the sequencer
	a_sq_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		sq_res.done |-> (state_q == pla_pkg::ST_MUL))
		else $error("squaring finished outside its state");

	a_rt_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		rt_res.done |-> (state_q == pla_pkg::ST_ROOT))
		else $error("root finished outside its state");

	// a clamped total is always the maximum
	a_sat_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == pla_pkg::TOTAL_MAX))
		else $error("saturated flag with total below maximum");

endmodule

>>> verif/polyline_length_accumulator_top_tb.sv
// ---------------------------------------------------------------------------
// polyline_length_accumulator_top_tb: self-checking bench for the path
// length accumulator
// Drives points over the input stream and predicts each emitted total with
// an exact integer model of the segment square roots and the saturating sum.
// Results are checked field by field in order. Stimulus covers directed
// corner cases and random phases of well-formed paths mixed with stray
// flags. Both sides idle at random, and one phase runs without any idling.
// ---------------------------------------------------------------------------
module polyline_length_accumulator_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] COORD_MIN  = 16'h8000;
	localparam logic [15:0] COORD_MAX  = 16'h7FFF;
	localparam int          MAX_GAP    = 18;
	localparam int          SETTLE_CYC = 40;

	typedef struct packed {
		logic [pla_pkg::TOTAL_W-1:0] length;
		logic                        sat;
	} path_total_t;

	// predicts path totals and checks emitted ones
	class path_length_scoreboard;
		logic [pla_pkg::COORD_W-1:0] prev_x, prev_y, prev_z;
		logic [pla_pkg::TOTAL_W-1:0] total;
		logic                        clamped;
		logic                        three_d;
		path_total_t                 expected_q[$];
		int                          errors;

		function new();
			prev_x  = '0;
			prev_y  = '0;
			prev_z  = '0;
			total   = '0;
			clamped = 1'b0;
			three_d = 1'b0;
			errors  = 0;
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function logic [pla_pkg::COORD_W-1:0] coord_gap(logic [pla_pkg::COORD_W-1:0] a,
				logic [pla_pkg::COORD_W-1:0] b);
			int d;
			d = $signed(a) - $signed(b);
			return pla_pkg::COORD_W'((d < 0) ? -d : d);
		endfunction

		// floor of the square root, one result bit at a time
		function logic [17:0] root_floor(logic [33:0] v);
			logic [17:0] r;
			logic [17:0] c;
			r = '0;
			for (int b = 17; b >= 0; b--) begin
				c = r | (18'd1 << b);
				if (36'(c) * 36'(c) <= 36'(v))
					r = c;
			end
			return r;
		endfunction

		// advance the path state by one accepted point
		function void note_point(logic [pla_pkg::COORD_W-1:0] x,
				logic [pla_pkg::COORD_W-1:0] y, logic [pla_pkg::COORD_W-1:0] z,
				logic is_first, logic is_last);
			logic [pla_pkg::COORD_W-1:0] dx, dy, dz;
			logic [33:0]                 sq_sum;
			logic [17:0]                 seg;
			path_total_t                 res;
			if (is_first) begin
				total   = '0;
				clamped = 1'b0;
			end else begin
				dx     = coord_gap(x, prev_x);
				dy     = coord_gap(y, prev_y);
				dz     = coord_gap(z, prev_z);
				sq_sum = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
				if (three_d)
					sq_sum += 34'(dz) * 34'(dz);
				seg = root_floor(sq_sum);
				if (pla_pkg::TOTAL_W'(seg) > pla_pkg::TOTAL_MAX - total) begin
					total   = pla_pkg::TOTAL_MAX;
					clamped = 1'b1;
				end else begin
					total += pla_pkg::TOTAL_W'(seg);
				end
			end
			prev_x = x;
			prev_y = y;
			prev_z = z;
			if (is_last) begin
				res.length = total;
				res.sat    = clamped;
				expected_q.push_back(res);
			end
		endfunction

		// compare one emitted total with the oldest prediction
		task check_result(logic [pla_pkg::TOTAL_W-1:0] length, logic sat);
			path_total_t exp_res;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected total %0d sat %0b", length, sat));
				return;
			end
			exp_res = expected_q.pop_front();
			if (length !== exp_res.length)
				report($sformatf("path_length %0d, predicted %0d", length, exp_res.length));
			if (sat !== exp_res.sat)
				report($sformatf("saturated %0b, predicted %0b", sat, exp_res.sat));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	path_length_scoreboard sb;
	bit                    quiet_phase;

	polyline_length_accumulator_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int draw_gap();
		return quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// offer one point and hold it until it is taken
	task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic is_first, logic is_last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		s_tuser  <= is_first;
		s_tlast  <= is_last;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sb.note_point(x, y, z, is_first, is_last);
	endtask

	function automatic logic [15:0] pick_coord(logic [15:0] near);
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return near + 16'($urandom_range(0, 512)) - 16'd256;
		endcase
	endfunction

	task automatic send_near(logic is_first, logic is_last);
		send_point(pick_coord(sb.prev_x), pick_coord(sb.prev_y), pick_coord(sb.prev_z),
			is_first, is_last);
	endtask

	// wait until every total has arrived and the block has gone quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_mode(logic three_d);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= three_d;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.three_d = three_d;
	endtask

	task automatic run_random(int quota);
		int sent;
		int mids;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 9) == 0) begin
					send_near(1'b1, 1'b1);
					sent++;
				end else begin
					mids = $urandom_range(0, 6);
					send_near(1'b1, 1'b0);
					repeat (mids) send_near(1'b0, 1'b0);
					send_near(1'b0, 1'b1);
					sent += mids + 2;
				end
			end else begin
				// stray flags: continue or restart paths at random
				send_near(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	// accept totals with random stalls
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			sb.check_result(m_tdata, m_tuser[0]);
		end
	end

	// stimulus
	initial begin
		sb          = new();
		quiet_phase = 1'b0;
		arst_n      = 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= '0;
		s_tlast     <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2D: segment from the origin, one-point path, extreme and zero segments
		send_point(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
		send_point(16'd5, 16'd7, 16'd0, 1'b1, 1'b1);
		send_point(COORD_MIN, COORD_MAX, 16'd0, 1'b1, 1'b0);
		send_point(COORD_MAX, COORD_MIN, 16'd0, 1'b0, 1'b0);
		send_point(COORD_MAX, COORD_MIN, 16'd0, 1'b0, 1'b1);
		send_point(16'd0, 16'd0, COORD_MIN, 1'b0, 1'b1);
		drain();

		// 3D: z-only segment and the longest diagonal
		write_mode(1'b1);
		send_point(16'd1, 16'd2, 16'd3, 1'b1, 1'b0);
		send_point(16'd1, 16'd2, COORD_MAX, 1'b0, 1'b0);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
		drain();

		// back to 2D inside the same path; z change must be ignored
		write_mode(1'b0);
		send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b1);
		send_point(16'h7FFE, 16'h7FFE, 16'd0, 1'b0, 1'b1);
		send_point(16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, 1'b1);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			write_mode(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
			quiet_phase = (phase == 3);
			run_random(110);
			drain();
		end

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hard stop; the longest legal run is well under a tenth of this
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
